// ===== hw/rtl/bmp_stream_encoder_unit_defines.svh =====
// Assertion macros used by the checker file, bse_checker.sv.
`ifndef BMP_STREAM_ENCODER_UNIT_DEFINES_SVH
`define BMP_STREAM_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define BSE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bse: same-cycle check failed");

// Next-cycle implication.
`define BSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bse: next-cycle check failed");

`endif

// ===== hw/rtl/bse_pkg.sv =====
`default_nettype none

package bse_pkg;

  localparam int DIM_W      = 13;
  localparam int ROWB_W     = 15;
  localparam int ARRAY_W    = DIM_W + ROWB_W;
  localparam int CFG_IDX_W  = 4;
  localparam int POS_W      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [7:0]  MAGIC_B      = 8'h42;
  localparam logic [7:0]  MAGIC_M      = 8'h4D;
  localparam logic [31:0] HDR_BYTES    = 32'd54;
  localparam logic [31:0] PIX_OFFSET   = 32'h36;
  localparam logic [31:0] DIB_SIZE     = 32'h28;
  localparam logic [31:0] PLANES_BPP   = 32'h0018_0001;
  localparam logic [31:0] PIX_PER_M    = 32'h0000_0B13;

  localparam logic [POS_W-1:0] POS_FIELDS = POS_W'(2);
  localparam logic [POS_W-1:0] POS_BLUE   = POS_W'(54);
  localparam logic [POS_W-1:0] POS_GREEN  = POS_W'(55);
  localparam logic [POS_W-1:0] POS_RED    = POS_W'(56);

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [ARRAY_W-1:0] array_t;
  typedef logic [POS_W-1:0]   pos_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bse_ifs.sv =====
`default_nettype none

interface bse_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface bse_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_of_run;
  logic       frame_end;
  modport source (output valid, byte_value, last_of_run, frame_end, input ready);
  modport sink   (input valid, byte_value, last_of_run, frame_end, output ready);
endinterface

interface bse_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [bse_pkg::CFG_IDX_W-1:0] index;
  logic [bse_pkg::DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bmp_stream_encoder_unit.sv =====
// channel  dir  payload                                   transaction
// cfg      in   index[3:0], data[12:0]                    one register write
// pixel    in   red, green, blue (8 b each)               one pixel, file order
// stream   out  byte_value, last_of_run, frame_end        one file byte
//
// Each pixel is issued as 3 bytes, plus 0-3 row padding bytes, plus the 54-byte
// header on the first pixel of a frame, all through the byte-wide output register.
// The next pixel is taken in the cycle its predecessor's last byte is issued.
// Stalls on stream hold the output register and the byte sequencer.
// rst clears the column and row counters, busy state and output valid; dimensions reset to 1.
`default_nettype none

module bmp_stream_encoder_unit #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire          clk,
  input  wire          rst,
  bse_cfg_if.sink      cfg,
  bse_pixel_if.sink    pixel,
  bse_byte_if.source   stream
);

  import bse_pkg::*;

  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if ({4'b0, v} > 17'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end
    return r;
  endfunction

  dim_t       frame_width;
  dim_t       frame_height;
  dim_t       column_count;
  dim_t       row_count;

  logic       busy;
  pos_t       pos;
  pos_t       end_pos;
  logic       frame_done;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  array_t     array_bytes;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_fend;

  logic                  cfg_acc;
  logic                  pix_acc;
  logic                  emit;
  logic                  run_done;
  logic                  need_hdr;
  logic                  row_end;
  logic                  frm_end;
  logic [ROWB_W-1:0]     row_bytes;
  array_t                array_next;
  logic [31:0]           file_size;
  logic [31:0]           word;
  pos_t                  hpos;
  logic [7:0]            byte_next;

  assign cfg.ready    = 1'b1;
  assign cfg_acc      = cfg.valid;
  assign emit         = busy && (!out_valid || stream.ready);
  assign run_done     = emit && (pos == end_pos);
  assign pixel.ready  = !busy || run_done;
  assign pix_acc      = pixel.valid && pixel.ready;

  assign need_hdr   = (column_count == '0) && (row_count == '0);
  assign row_end    = ({1'b0, column_count} + 14'd1) >= {1'b0, frame_width};
  assign frm_end    = row_end && (({1'b0, row_count} + 14'd1) >= {1'b0, frame_height});
  assign row_bytes  = ((ROWB_W'(frame_width) * ROWB_W'(3)) + ROWB_W'(3)) & ~ROWB_W'(3);
  assign array_next = ARRAY_W'(frame_height) * ARRAY_W'(row_bytes);

  assign file_size  = HDR_BYTES + 32'(array_bytes);
  assign hpos       = pos - POS_FIELDS;

  always_comb begin
    case (hpos[POS_W-1:2])
      4'd0:    word = file_size;
      4'd2:    word = PIX_OFFSET;
      4'd3:    word = DIB_SIZE;
      4'd4:    word = 32'(frame_width);
      4'd5:    word = 32'(frame_height);
      4'd6:    word = PLANES_BPP;
      4'd8:    word = 32'(array_bytes);
      4'd9:    word = PIX_PER_M;
      4'd10:   word = PIX_PER_M;
      default: word = '0;
    endcase
  end

  always_comb begin
    if (pos == '0) begin
      byte_next = MAGIC_B;
    end else if (pos == POS_W'(1)) begin
      byte_next = MAGIC_M;
    end else if (pos < POS_BLUE) begin
      byte_next = word[8*hpos[1:0] +: 8];
    end else if (pos == POS_BLUE) begin
      byte_next = blue;
    end else if (pos == POS_GREEN) begin
      byte_next = green;
    end else if (pos == POS_RED) begin
      byte_next = red;
    end else begin
      byte_next = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(1);
      frame_height <= DIM_W'(1);
      column_count <= '0;
      row_count    <= '0;
      busy         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_acc && (cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT)) begin
        if (cfg.index == REG_FRAME_WIDTH) begin
          frame_width <= clamp_dim(cfg.data);
        end else begin
          frame_height <= clamp_dim(cfg.data);
        end
        column_count <= '0;
        row_count    <= '0;
      end else if (pix_acc) begin
        if (row_end) begin
          column_count <= '0;
          row_count    <= frm_end ? '0 : row_count + DIM_W'(1);
        end else begin
          column_count <= column_count + DIM_W'(1);
        end
      end

      if (pix_acc) begin
        busy <= 1'b1;
      end else if (run_done) begin
        busy <= 1'b0;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      pos         <= need_hdr ? '0 : POS_BLUE;
      end_pos     <= POS_RED + (row_end ? POS_W'(frame_width[1:0]) : '0);
      frame_done  <= frm_end;
      red         <= pixel.red;
      green       <= pixel.green;
      blue        <= pixel.blue;
      array_bytes <= array_next;
    end else if (emit) begin
      pos <= pos + POS_W'(1);
    end
    if (emit) begin
      out_byte <= byte_next;
      out_last <= run_done;
      out_fend <= run_done && frame_done;
    end
  end

  assign stream.valid       = out_valid;
  assign stream.byte_value  = out_byte;
  assign stream.last_of_run = out_last;
  assign stream.frame_end   = out_fend;

endmodule

`default_nettype wire

// ===== hw/rtl/bse_checker.sv =====
`default_nettype none
`include "bmp_stream_encoder_unit_defines.svh"

module bse_checker (
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       out_last,
  input wire       out_fend
);

  `BSE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_fend))
  `BSE_ASSERT_SAME(a_fend_is_last, clk, rst, out_valid && out_fend, out_last)
  `BSE_ASSERT_SAME(a_quiet_after_rst, clk, rst, $past(rst), !out_valid)

endmodule

bind bmp_stream_encoder_unit bse_checker u_bse_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (stream.valid),
  .out_ready (stream.ready),
  .out_byte  (stream.byte_value),
  .out_last  (stream.last_of_run),
  .out_fend  (stream.frame_end)
);

`default_nettype wire
